// ===== design/deq_pkg.sv =====
// deq_pkg: command codes, widths and the item type shared by the deque modules
// no dependencies
package deq_pkg;

    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int QDEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]         op;
        logic signed [WORD_W-1:0] word;
    } deq_item_t;

endpackage

// ===== design/deq_ram.sv =====
// deq_ram: generic ram, one write port, two registered read ports
// no dependencies
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== design/deq_front.sv =====
// deq_front: takes input words, folds unused command codes into peek and
// holds them in a short queue for the back end; uses deq_pkg
module deq_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [deq_pkg::CMD_W-1:0]          command,
    input  logic signed [deq_pkg::WORD_W-1:0]  data_value,
    output logic                               item_valid,
    input  logic                               item_ready,
    output deq_pkg::deq_item_t                 item
);

    import deq_pkg::*;

    localparam int QPW = $clog2(QDEPTH);

    deq_item_t          q_reg [QDEPTH];
    logic [QPW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QPW:0]       fill_reg, fill_next;
    deq_item_t          in_item;
    logic               push, pop;

    // anything beyond delete rear behaves as peek
    always_comb
    begin
        in_item.word = data_value;
        case (command)
            CMD_INS_FRONT: in_item.op = CMD_INS_FRONT;
            CMD_INS_REAR:  in_item.op = CMD_INS_REAR;
            CMD_DEL_FRONT: in_item.op = CMD_DEL_FRONT;
            CMD_DEL_REAR:  in_item.op = CMD_DEL_REAR;
            default:       in_item.op = CMD_PEEK;
        endcase
    end

    assign in_ready   = (fill_reg != (QPW+1)'(QDEPTH));
    assign item_valid = (fill_reg != '0);
    assign item       = q_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== design/deq_back.sv =====
// deq_back: carries out deque commands on a ring with head pointer and count,
// reads both ends from the word ram and fills the output register; uses deq_pkg, deq_ram
module deq_back #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  deq_pkg::deq_item_t                  item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                ignored,
    output logic [$clog2(CAPACITY+1)-1:0]       count,
    output logic                                is_full,
    output logic                                is_empty,
    output logic signed [deq_pkg::WORD_W-1:0]   front_value,
    output logic signed [deq_pkg::WORD_W-1:0]   rear_value
);

    import deq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam int SW = CW + 1;

    localparam logic S_EXEC = 1'b0;
    localparam logic S_LOAD = 1'b1;

    logic                state_reg;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                out_valid_reg;
    logic                pend_ign_reg, ign;
    logic                byp_front_reg, byp_rear_reg;
    logic [WORD_W-1:0]   byp_word_reg;

    logic                take, full_now, empty_now, wr_c, we;
    logic [AW-1:0]       head_dec, head_inc, tail_idx, waddr, rear_idx;
    logic [SW-1:0]       tail_sum, rear_sum;
    logic [CW-1:0]       rear_off;
    logic                byp_front, byp_rear;
    logic [WORD_W-1:0]   rd_front, rd_rear;

    assign item_ready = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign take       = item_valid && item_ready;

    always_comb
    begin
        full_now  = (cnt_reg == CW'(CAPACITY));
        empty_now = (cnt_reg == '0);
        head_dec  = (head_reg == '0) ? AW'(CAPACITY-1) : head_reg - 1'b1;
        head_inc  = (head_reg == AW'(CAPACITY-1)) ? '0 : head_reg + 1'b1;
        tail_sum  = SW'(head_reg) + SW'(cnt_reg);
        tail_idx  = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY))
                                                : AW'(tail_sum);
        head_next = head_reg;
        cnt_next  = cnt_reg;
        ign       = 1'b0;
        wr_c      = 1'b0;
        waddr     = head_reg;
        case (item.op)
            CMD_INS_FRONT:
            begin
                if (full_now)
                begin
                    ign = 1'b1;
                end
                else
                begin
                    head_next = head_dec;
                    waddr     = head_dec;
                    wr_c      = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            CMD_INS_REAR:
            begin
                if (full_now)
                begin
                    ign = 1'b1;
                end
                else
                begin
                    waddr    = tail_idx;
                    wr_c     = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            CMD_DEL_FRONT:
            begin
                if (empty_now)
                begin
                    ign = 1'b1;
                end
                else
                begin
                    head_next = head_inc;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            CMD_DEL_REAR:
            begin
                if (empty_now)
                begin
                    ign = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                ign = 1'b0;
            end
        endcase

        rear_off = (cnt_next == '0) ? '0 : cnt_next - 1'b1;
        rear_sum = SW'(head_next) + SW'(rear_off);
        rear_idx = (rear_sum >= SW'(CAPACITY)) ? AW'(rear_sum - SW'(CAPACITY))
                                               : AW'(rear_sum);

        // the word just written is one end (or both, with a single word held);
        // the ram read of that end is replaced by the word itself
        byp_front = wr_c && ((item.op == CMD_INS_FRONT) || (cnt_next == CW'(1)));
        byp_rear  = wr_c && ((item.op == CMD_INS_REAR)  || (cnt_next == CW'(1)));
        we        = take && wr_c;
    end

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (item.word),
        .raddr_a (head_next),
        .raddr_b (rear_idx),
        .rdata_a (rd_front),
        .rdata_b (rd_rear)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EXEC;
            head_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= S_LOAD;
                head_reg  <= head_next;
                cnt_reg   <= cnt_next;
            end
            else if (state_reg == S_LOAD)
            begin
                state_reg <= S_EXEC;
            end

            if (state_reg == S_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_ign_reg  <= ign;
            byp_front_reg <= byp_front;
            byp_rear_reg  <= byp_rear;
            byp_word_reg  <= item.word;
        end
        if (state_reg == S_LOAD)
        begin
            ignored  <= pend_ign_reg;
            count    <= cnt_reg;
            is_full  <= (cnt_reg == CW'(CAPACITY));
            is_empty <= (cnt_reg == '0);
            if (cnt_reg == '0)
            begin
                front_value <= '0;
                rear_value  <= '0;
            end
            else
            begin
                front_value <= byp_front_reg ? byp_word_reg : rd_front;
                rear_value  <= byp_rear_reg  ? byp_word_reg : rd_rear;
            end
        end
    end

    assign out_valid = out_valid_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("held count above capacity");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= AW'(CAPACITY-1))
        else $error("head pointer out of range");

    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD |=> state_reg == S_EXEC && out_valid_reg)
        else $error("load cycle did not present a result");

    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (!out_valid_reg || out_ready))
        else $error("command started while output register blocked");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg == S_LOAD) && is_empty |-> front_value == '0 && rear_value == '0)
        else $error("empty result carries nonzero end words");

endmodule

// ===== design/double_ended_queue.sv =====
// double_ended_queue: top level of the bounded deque of signed 32-bit words
// depends on deq_pkg, deq_front, deq_back (which holds deq_ram)
//
// usage:
//   input channel in_valid/in_ready carries command and data_value; output
//   channel out_valid/out_ready returns ignored, count, is_full, is_empty,
//   front_value and rear_value, one result word for every input word.
//   commands: insert front, insert rear, delete front, delete rear, peek;
//   codes above peek act as peek. an insert when full or a delete when empty
//   leaves the contents alone and returns ignored high.
//   a word accepted passes through the input queue, then the back end's
//   execute state and its load state, in which the ram's registered read of
//   both queue ends fills the output register; no command is taken in load.
//   a 2-entry queue lets the input keep accepting while the back end works
//   or the output waits; when the receiver stalls, the result holds in the
//   output register, the back end stops and the input queue fills, then
//   in_ready drops.
//   reset empties the deque (count 0, head 0) and the input queue; the word
//   ram is not cleared, only positions written by inserts are ever read.
module double_ended_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [deq_pkg::CMD_W-1:0]          command,
    input  logic signed [deq_pkg::WORD_W-1:0]  data_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               ignored,
    output logic [$clog2(CAPACITY+1)-1:0]      count,
    output logic                               is_full,
    output logic                               is_empty,
    output logic signed [deq_pkg::WORD_W-1:0]  front_value,
    output logic signed [deq_pkg::WORD_W-1:0]  rear_value
);

    import deq_pkg::*;

    deq_item_t item;
    logic      item_valid;
    logic      item_ready;

    deq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .data_value (data_value),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    deq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ignored     (ignored),
        .count       (count),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .front_value (front_value),
        .rear_value  (rear_value)
    );

endmodule

// ===== dv/deque_scoreboard_pkg.sv =====
// deque_scoreboard_pkg: status type and scoreboard class for the deque testbench
// depends on deq_pkg for the command codes and word width
package deque_scoreboard_pkg;

    import deq_pkg::*;

    localparam int DEQ_CAPACITY = 16;

    typedef struct packed {
        logic                     ignored;
        logic [4:0]               count;
        logic                     is_full;
        logic                     is_empty;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
    } deque_status_t;

    class deque_scoreboard;

        logic signed [WORD_W-1:0] ring [DEQ_CAPACITY];
        logic [3:0]               head;
        logic [4:0]               held;
        deque_status_t            status_q[$];
        int                       mismatches;
        int                       checked;
        int                       accepted;
        int                       ignored_seen;
        int                       full_seen;
        int                       empty_seen;

        function new();
            foreach (ring[i])
                ring[i] = '0;
            head = '0;
            held = '0;
            mismatches = 0;
            checked = 0;
            accepted = 0;
            ignored_seen = 0;
            full_seen = 0;
            empty_seen = 0;
        endfunction

        // apply one accepted command to the shadow deque and queue its status word
        function void note_command(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] word);
            deque_status_t st;
            logic [3:0]    idx;
            logic          full;
            logic          empty;
            full = (held == DEQ_CAPACITY);
            empty = (held == 0);
            st = '0;
            case (cmd)
                CMD_INS_FRONT:
                    if (full)
                        st.ignored = 1'b1;
                    else
                    begin
                        head = head - 4'd1;
                        ring[head] = word;
                        held = held + 5'd1;
                    end
                CMD_INS_REAR:
                    if (full)
                        st.ignored = 1'b1;
                    else
                    begin
                        idx = head + held[3:0];
                        ring[idx] = word;
                        held = held + 5'd1;
                    end
                CMD_DEL_FRONT:
                    if (empty)
                        st.ignored = 1'b1;
                    else
                    begin
                        head = head + 4'd1;
                        held = held - 5'd1;
                    end
                CMD_DEL_REAR:
                    if (empty)
                        st.ignored = 1'b1;
                    else
                        held = held - 5'd1;
                default:
                    ;
            endcase
            st.count = held;
            st.is_full = (held == DEQ_CAPACITY);
            st.is_empty = (held == 0);
            if (held != 0)
            begin
                // rear sits at head + held - 1, which wraps to head - 1 when full
                idx = head + held[3:0] - 4'd1;
                st.front_value = ring[head];
                st.rear_value = ring[idx];
            end
            accepted++;
            if (st.ignored)
                ignored_seen++;
            if (st.is_full)
                full_seen++;
            if (st.is_empty)
                empty_seen++;
            status_q.push_back(st);
        endfunction

        function void compare_field(string field, logic signed [63:0] expected,
                                    logic signed [63:0] actual);
            if (expected !== actual)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, expected, actual);
                mismatches++;
            end
        endfunction

        function void check_result(deque_status_t got);
            deque_status_t want;
            if (status_q.size() == 0)
            begin
                $error("status word arrived with no command outstanding");
                mismatches++;
                return;
            end
            want = status_q.pop_front();
            checked++;
            compare_field("ignored", want.ignored, got.ignored);
            compare_field("count", want.count, got.count);
            compare_field("is_full", want.is_full, got.is_full);
            compare_field("is_empty", want.is_empty, got.is_empty);
            compare_field("front_value", want.front_value, got.front_value);
            compare_field("rear_value", want.rear_value, got.rear_value);
        endfunction

        function int outstanding();
            return status_q.size();
        endfunction

    endclass

endpackage

// ===== dv/tb.sv =====
// tb: top-level testbench for double_ended_queue, directed and random commands
// depends on deq_pkg, deque_scoreboard_pkg and the double_ended_queue rtl
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;
    import deque_scoreboard_pkg::*;

    localparam int N_RANDOM     = 930;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_GAP      = 11;
    localparam int N_CODES      = 1 << CMD_W;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         command = CMD_PEEK;
    logic signed [WORD_W-1:0] data_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     ignored;
    logic [4:0]               count;
    logic                     is_full;
    logic                     is_empty;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;

    deque_scoreboard sb = new();
    bit              send_calm = 1'b0;
    int              cycle_count = 0;

    double_ended_queue #(
        .CAPACITY(DEQ_CAPACITY)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .data_value (data_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ignored    (ignored),
        .count      (count),
        .is_full    (is_full),
        .is_empty   (is_empty),
        .front_value(front_value),
        .rear_value (rear_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // present one command word after a random gap (none while send_calm is set) and hold it until accepted
    task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] word);
        int gap;
        gap = send_calm ? 0 : $urandom_range(MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        data_value <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_command(cmd, word);
    endtask

    task automatic wait_for_status();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls per word, with calm stretches of back-to-back reads
    initial
    begin
        int            stall;
        int            left;
        bit            calm;
        deque_status_t got;
        left = 0;
        calm = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (left == 0)
            begin
                calm = ($urandom_range(3) == 0);
                left = $urandom_range(80, 20);
            end
            left--;
            stall = calm ? 0 : $urandom_range(MAX_GAP);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got.ignored = ignored;
            got.count = count;
            got.is_full = is_full;
            got.is_empty = is_empty;
            got.front_value = front_value;
            got.rear_value = rear_value;
            sb.check_result(got);
        end
    end

    initial
    begin
        int               i;
        int               ins_pct;
        logic [CMD_W-1:0] cmd;
        logic signed [WORD_W-1:0] word;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: peek and both deletes
        send_command(CMD_PEEK, pick_word());
        send_command(CMD_DEL_FRONT, 32'sh00001234);
        send_command(CMD_DEL_REAR, -1);
        // fill to capacity from both ends, extremes first
        for (i = 0; i < DEQ_CAPACITY; i++)
        begin
            case (i)
                0: word = WORD_MAX;
                1: word = WORD_MIN;
                2: word = -1;
                3: word = '0;
                default: word = $urandom;
            endcase
            send_command(i[0] ? CMD_INS_REAR : CMD_INS_FRONT, word);
        end
        // inserts into a full queue
        send_command(CMD_INS_FRONT, 32'sh00000007);
        send_command(CMD_INS_REAR, -7);
        // codes above peek behave as peek
        for (i = int'(CMD_PEEK) + 1; i < N_CODES; i++)
            send_command(i[CMD_W-1:0], $urandom);
        wait_for_status();

        ins_pct = 50;
        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0: ins_pct = 80;
                    1: ins_pct = 20;
                    default: ins_pct = 50;
                endcase
                send_calm = ($urandom_range(3) == 0);
            end
            if ($urandom_range(99) < 6)
                cmd = CMD_W'($urandom_range(N_CODES - 1, int'(CMD_PEEK)));
            else if ($urandom_range(99) < ins_pct)
                cmd = $urandom_range(1) ? CMD_INS_REAR : CMD_INS_FRONT;
            else
                cmd = $urandom_range(1) ? CMD_DEL_REAR : CMD_DEL_FRONT;
            send_command(cmd, pick_word());
            if (i % 300 == 299)
                wait_for_status();
        end
        in_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d commands, %0d of them ignored; full %0d times, empty %0d times",
                 sb.accepted, sb.ignored_seen, sb.full_seen, sb.empty_seen);
        $display("status words checked: %0d, mismatches: %0d", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/deq_pkg.sv
design/deq_ram.sv
design/deq_front.sv
design/deq_back.sv
design/double_ended_queue.sv
dv/deque_scoreboard_pkg.sv
dv/tb.sv
